### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CHK_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while in reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/csvs_pkg.sv
// ----------------------------------------------------------------------------
// csvs_pkg
// Shared constants and types of the CSV line field splitter.
// ----------------------------------------------------------------------------
package csvs_pkg;

  localparam int HOLD_DEPTH = 32;
  localparam int HOLD_AW    = $clog2(HOLD_DEPTH);
  localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);

  localparam logic [7:0] NUL_CH      = 8'd0;
  localparam logic [7:0] TAB_CH      = 8'd9;
  localparam logic [7:0] CR_CH       = 8'd13;
  localparam logic [7:0] SPACE_CH    = 8'd32;
  localparam logic [7:0] QUOTE_CH    = 8'd34;
  localparam logic [7:0] COMMA_CH    = 8'd44;
  localparam logic [7:0] DELIM_RESET = COMMA_CH;

  typedef enum logic [2:0] {
    PM_LINE_START,
    PM_FIELD_LEAD,
    PM_PLAIN,
    PM_QUOTED,
    PM_QUOTE_SEEN,
    PM_SKIP,
    PM_DRAIN,
    PM_DRAIN_EMPTY
  } parse_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_EMIT,
    ST_FINAL
  } seq_state_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_char;
    logic       last_field;
    logic       empty_line;
    logic       ws_overflow;
    logic       last;
  } out_item_t;

endpackage

### rtl/core/csv_line_field_splitter_top.sv
// ----------------------------------------------------------------------------
// csv_line_field_splitter_top
// Splits a text line, one byte per transaction, into field bytes and
// field-end marks; trims whitespace and handles quoted fields while the delimiter is a comma.
// ----------------------------------------------------------------------------
//   channel  dir  handshake             payload
//   in       in   in_valid / in_stall   in_ch, in_line_end
//   out      out  out_valid / out_stall out_char, out_is_char, out_last_field,
//                                       out_empty_line, out_ws_overflow, out_last
//   cfg      in   cfg_valid / cfg_ready cfg_field_delimiter
//
// A transaction goes through idle and evaluate when it yields at most one result and
// the output register is free; a byte that releases held whitespace bytes adds a read
// and an emit state per byte and a final state, set by the single read port of the
// whitespace RAM. Output stalls hold the sequencer. Synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
module csv_line_field_splitter_top
  import csvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_line_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_is_char,
  output logic       out_last_field,
  output logic       out_empty_line,
  output logic       out_ws_overflow,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_field_delimiter
);

  seq_state_t           state_r, state_nxt;
  parse_mode_t          mode_r, mode_nxt;
  logic [HOLD_CW-1:0]   held_count_r, held_count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [HOLD_AW-1:0]   rd_idx_r, rd_idx_nxt;
  logic [7:0]           delim_r;
  logic [7:0]           item_ch_r;
  logic                 item_eol_r;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic                 slot_free;
  logic                 in_accept;
  logic                 ch_ws;
  logic                 ch_delim;
  logic                 quoting;
  logic                 flush_done;
  logic [7:0]           ram_rdata;

  // evaluation of the latched transaction
  logic                 ev_emit;
  logic                 ev_flush;
  logic                 ev_clear;
  logic                 ev_push;
  logic                 ev_ovf;
  parse_mode_t          ev_mode;
  out_item_t            ev_item;
  logic                 eval_go;
  logic                 load_out;

  assign slot_free  = !out_valid_r || !out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign quoting    = (delim_r == COMMA_CH);
  assign ch_delim   = (item_ch_r == delim_r);
  assign ch_ws      = (((item_ch_r >= TAB_CH) && (item_ch_r <= CR_CH)) ||
                       (item_ch_r == SPACE_CH)) && !ch_delim;
  assign flush_done = (({1'b0, rd_idx_r} + HOLD_CW'(1)) == held_count_r);

  always_comb begin
    ev_emit  = 1'b0;
    ev_flush = 1'b0;
    ev_clear = 1'b0;
    ev_push  = 1'b0;
    ev_ovf   = 1'b0;
    ev_mode  = mode_r;
    ev_item  = '{out_char: item_ch_r, is_char: 1'b1, last_field: 1'b0,
                 empty_line: 1'b0, ws_overflow: 1'b0, last: 1'b1};
    if (item_eol_r) begin
      ev_emit  = 1'b1;
      ev_clear = 1'b1;
      ev_mode  = PM_LINE_START;
      ev_item.out_char = NUL_CH;
      ev_item.is_char  = 1'b0;
      if (mode_r == PM_LINE_START || mode_r == PM_DRAIN_EMPTY) begin
        ev_item.empty_line = 1'b1;
      end else begin
        ev_item.last_field  = 1'b1;
        ev_item.ws_overflow = ovf_r;
      end
    end else if (mode_r == PM_DRAIN || mode_r == PM_DRAIN_EMPTY) begin
      ev_mode = mode_r;
    end else if (item_ch_r == NUL_CH) begin
      ev_mode = (mode_r == PM_LINE_START) ? PM_DRAIN_EMPTY : PM_DRAIN;
    end else if (ch_delim && mode_r != PM_QUOTED) begin
      ev_emit  = 1'b1;
      ev_clear = 1'b1;
      ev_mode  = PM_FIELD_LEAD;
      ev_item.out_char    = NUL_CH;
      ev_item.is_char     = 1'b0;
      ev_item.ws_overflow = ovf_r;
    end else begin
      unique case (mode_r)
        PM_LINE_START, PM_FIELD_LEAD: begin
          if (ch_ws) begin
            ev_mode = PM_FIELD_LEAD;
          end else if (item_ch_r == QUOTE_CH && quoting) begin
            ev_mode = PM_QUOTED;
          end else begin
            ev_emit = 1'b1;
            ev_mode = PM_PLAIN;
          end
        end
        PM_PLAIN: begin
          if (ch_ws) begin
            if (held_count_r < HOLD_CW'(HOLD_DEPTH)) begin
              ev_push = 1'b1;
            end else begin
              ev_ovf = 1'b1;
            end
          end else if (held_count_r != '0) begin
            ev_flush = 1'b1;
          end else begin
            ev_emit = 1'b1;
          end
        end
        PM_QUOTED: begin
          if (item_ch_r == QUOTE_CH) begin
            ev_mode = PM_QUOTE_SEEN;
          end else begin
            ev_emit = 1'b1;
          end
        end
        PM_QUOTE_SEEN: begin
          if (item_ch_r == QUOTE_CH) begin
            ev_emit = 1'b1;
            ev_mode = PM_QUOTED;
          end else begin
            ev_mode = PM_SKIP;
          end
        end
        default: begin
          ev_mode = mode_r;
        end
      endcase
    end
  end

  assign eval_go = (state_r == ST_EVAL) && (!ev_emit || slot_free);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (eval_go) begin
          state_nxt = ev_flush ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = flush_done ? ST_FINAL : ST_READ;
        end
      end
      ST_FINAL: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    mode_nxt       = mode_r;
    held_count_nxt = held_count_r;
    ovf_nxt        = ovf_r;
    rd_idx_nxt     = rd_idx_r;
    load_out       = 1'b0;
    out_item_nxt   = out_item_r;
    unique case (state_r)
      ST_EVAL: begin
        if (eval_go) begin
          mode_nxt     = ev_mode;
          load_out     = ev_emit;
          if (ev_emit) begin
            out_item_nxt = ev_item;
          end
          rd_idx_nxt   = '0;
          if (ev_clear) begin
            held_count_nxt = '0;
            ovf_nxt        = 1'b0;
          end
          if (ev_push) begin
            held_count_nxt = held_count_r + HOLD_CW'(1);
          end
          if (ev_ovf) begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          load_out     = 1'b1;
          out_item_nxt = '{out_char: ram_rdata, is_char: 1'b1, last_field: 1'b0,
                           empty_line: 1'b0, ws_overflow: 1'b0, last: 1'b0};
          rd_idx_nxt   = rd_idx_r + HOLD_AW'(1);
        end
      end
      ST_FINAL: begin
        if (slot_free) begin
          load_out       = 1'b1;
          out_item_nxt   = '{out_char: item_ch_r, is_char: 1'b1, last_field: 1'b0,
                             empty_line: 1'b0, ws_overflow: 1'b0, last: 1'b1};
          held_count_nxt = '0;
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= PM_LINE_START;
      held_count_r <= '0;
      ovf_r        <= 1'b0;
      rd_idx_r     <= '0;
      delim_r      <= DELIM_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      held_count_r <= held_count_nxt;
      ovf_r        <= ovf_nxt;
      rd_idx_r     <= rd_idx_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        delim_r <= cfg_field_delimiter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_ch_r  <= in_ch;
      item_eol_r <= in_line_end;
    end
    out_item_r <= out_item_nxt;
  end

  csvs_ram #(
    .WIDTH (8),
    .DEPTH (HOLD_DEPTH)
  ) u_hold_ram (
    .clk   (clk),
    .we    (eval_go && ev_push),
    .waddr (held_count_r[HOLD_AW-1:0]),
    .wdata (item_ch_r),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  assign in_stall        = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_char        = out_item_r.out_char;
  assign out_is_char     = out_item_r.is_char;
  assign out_last_field  = out_item_r.last_field;
  assign out_empty_line  = out_item_r.empty_line;
  assign out_ws_overflow = out_item_r.ws_overflow;
  assign out_last        = out_item_r.last;

endmodule

### rtl/core/csvs_ram.sv
// ----------------------------------------------------------------------------
// csvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/csvs_checker.sv
// ----------------------------------------------------------------------------
// csvs_checker
// Port-level checks of the CSV line field splitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csvs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       out_is_char,
  input logic       out_last_field,
  input logic       out_empty_line,
  input logic       out_ws_overflow,
  input logic       out_last
);

  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `CHK_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)
  `CHK_IMPLIES(a_mark_zero_char, clk, rst_n, out_valid && !out_is_char, out_char == 8'd0)
  `CHK_IMPLIES(a_empty_line_shape, clk, rst_n, out_valid && out_empty_line,
               !out_is_char && out_last && !out_last_field && !out_ws_overflow)
  `CHK_IMPLIES(a_char_flags, clk, rst_n, out_valid && out_is_char,
               !out_last_field && !out_empty_line && !out_ws_overflow)

endmodule

bind csv_line_field_splitter_top csvs_checker u_csvs_checker (.*);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for csv_line_field_splitter_top. Feeds text lines one
// byte per transaction under several delimiter settings, idle and stall patterns,
// predicts field bytes and field-end marks in lock step, and checks every
// result in order against the prediction.
// ----------------------------------------------------------------------------
module testbench;
  import csvs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE      = 100;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } line_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_ch = 8'd0;
  logic       in_line_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_is_char;
  logic       out_last_field;
  logic       out_empty_line;
  logic       out_ws_overflow;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_field_delimiter = 8'd0;

  csv_line_field_splitter_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_ch               (in_ch),
    .in_line_end         (in_line_end),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_char            (out_char),
    .out_is_char         (out_is_char),
    .out_last_field      (out_last_field),
    .out_empty_line      (out_empty_line),
    .out_ws_overflow     (out_ws_overflow),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_field_delimiter (cfg_field_delimiter)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  line_byte_t  pending_bytes[$];
  out_item_t   expected_tokens[$];

  // splitter state as the bench sees it
  parse_mode_t line_mode = PM_LINE_START;
  logic [7:0]  delim = DELIM_RESET;
  logic [7:0]  ws_hold [HOLD_DEPTH];
  int          hold_cnt = 0;
  logic        ovf_seen = 1'b0;

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int bytes_in = 0;
  int tokens_checked = 0;
  int overflow_ends = 0;
  int delim_writes = 0;
  int quiet = 0;

  function automatic void add_token(logic [7:0] c, logic ic, logic lf, logic el, logic ov);
    out_item_t t;
    t = {c, ic, lf, el, ov, 1'b0};
    expected_tokens.insert(expected_tokens.size(), t);
  endfunction

  function automatic void close_field(logic lf);
    add_token(8'd0, 1'b0, lf, 1'b0, ovf_seen);
    hold_cnt = 0;
    ovf_seen = 1'b0;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return ((c >= 8'd9 && c <= 8'd13) || c == SPACE_CH) && c != delim;
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, logic eol);
    int        first;
    logic      quoting;
    out_item_t t;
    first = expected_tokens.size();
    quoting = (delim == COMMA_CH);
    if (eol) begin
      if (line_mode == PM_LINE_START || line_mode == PM_DRAIN_EMPTY) begin
        add_token(8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
        hold_cnt = 0;
        ovf_seen = 1'b0;
      end else begin
        close_field(1'b1);
      end
      line_mode = PM_LINE_START;
    end else if (line_mode != PM_DRAIN && line_mode != PM_DRAIN_EMPTY) begin
      if (c == NUL_CH) begin
        line_mode = (line_mode == PM_LINE_START) ? PM_DRAIN_EMPTY : PM_DRAIN;
      end else begin
        case (line_mode)
          PM_LINE_START, PM_FIELD_LEAD: begin
            if (c == delim) begin
              close_field(1'b0);
              line_mode = PM_FIELD_LEAD;
            end else if (is_space(c)) begin
              line_mode = PM_FIELD_LEAD;
            end else if (c == QUOTE_CH && quoting) begin
              line_mode = PM_QUOTED;
            end else begin
              add_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
              line_mode = PM_PLAIN;
            end
          end
          PM_PLAIN: begin
            if (c == delim) begin
              close_field(1'b0);
              line_mode = PM_FIELD_LEAD;
            end else if (is_space(c)) begin
              if (hold_cnt < HOLD_DEPTH) begin
                ws_hold[hold_cnt] = c;
                hold_cnt++;
              end else begin
                ovf_seen = 1'b1;
              end
            end else begin
              for (int i = 0; i < hold_cnt; i++) add_token(ws_hold[i], 1'b1, 1'b0, 1'b0, 1'b0);
              hold_cnt = 0;
              add_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
            end
          end
          PM_QUOTED: begin
            if (c == QUOTE_CH) line_mode = PM_QUOTE_SEEN;
            else add_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
          end
          PM_QUOTE_SEEN: begin
            if (c == QUOTE_CH) begin
              add_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
              line_mode = PM_QUOTED;
            end else if (c == delim) begin
              close_field(1'b0);
              line_mode = PM_FIELD_LEAD;
            end else begin
              line_mode = PM_SKIP;
            end
          end
          default: begin
            if (c == delim) begin
              close_field(1'b0);
              line_mode = PM_FIELD_LEAD;
            end
          end
        endcase
      end
    end
    if (expected_tokens.size() > first) begin
      t = expected_tokens[expected_tokens.size() - 1];
      t.last = 1'b1;
      expected_tokens[expected_tokens.size() - 1] = t;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("ERROR %0t: result %0d %s got %0d want %0d", $realtime, tokens_checked, what,
             got, want);
  endtask

  // driver
  always @(posedge clk) begin : drive_in
    line_byte_t b;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tokenize_byte(in_ch, in_line_end);
        bytes_in++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
          b = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_ch <= b.ch;
          in_line_end <= b.eol;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_out
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_char, out_is_char, out_last_field, out_empty_line, out_ws_overflow, out_last};
        if (expected_tokens.size() == 0) begin
          errors++;
          $display("ERROR %0t: result with none expected", $realtime);
        end else begin
          want = expected_tokens.pop_front();
          if (got.out_char !== want.out_char)
            report_mismatch("out_char", got.out_char, want.out_char);
          if (got.is_char !== want.is_char)
            report_mismatch("is_char", got.is_char, want.is_char);
          if (got.last_field !== want.last_field)
            report_mismatch("last_field", got.last_field, want.last_field);
          if (got.empty_line !== want.empty_line)
            report_mismatch("empty_line", got.empty_line, want.empty_line);
          if (got.ws_overflow !== want.ws_overflow)
            report_mismatch("ws_overflow", got.ws_overflow, want.ws_overflow);
          if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
        end
        if (got.ws_overflow === 1'b1) overflow_ends++;
        tokens_checked++;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("csv_line_field_splitter_top: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic void put(logic [7:0] c);
    line_byte_t b;
    b = {c, 1'b0};
    pending_bytes.insert(pending_bytes.size(), b);
  endfunction

  function automatic void put_eol();
    line_byte_t b;
    b = {8'($urandom), 1'b1};
    pending_bytes.insert(pending_bytes.size(), b);
  endfunction

  function automatic logic [7:0] pick_ws();
    int r;
    r = $urandom_range(9, 14);
    return (r == 14) ? SPACE_CH : 8'(r);
  endfunction

  function automatic logic [7:0] pick_text();
    case ($urandom_range(7))
      0: return 8'($urandom_range(128, 255));
      1: return 8'($urandom_range(1, 31));
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  function automatic void push_line();
    int nf;
    int n;
    case ($urandom_range(9))
      0: begin
        put_eol();
        return;
      end
      1: begin
        n = $urandom_range(1, 8);
        repeat (n) put(8'($urandom));
        put_eol();
        return;
      end
      default: ;
    endcase
    nf = $urandom_range(1, 3);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) put(delim);
      repeat ($urandom_range(0, 2)) put(pick_ws());
      if (delim == COMMA_CH && $urandom_range(2) == 0) begin
        put(QUOTE_CH);
        repeat ($urandom_range(0, 4)) begin
          n = $urandom_range(3);
          if (n == 0) begin
            put(QUOTE_CH);
            put(QUOTE_CH);
          end else if (n == 1) begin
            put(COMMA_CH);
          end else begin
            put(pick_text());
          end
        end
        if (f < nf - 1 || $urandom_range(3) != 0) begin
          put(QUOTE_CH);
          repeat ($urandom_range(0, 2)) put(pick_text());
        end
      end else begin
        repeat ($urandom_range(1, 2)) begin
          repeat ($urandom_range(1, 3)) put(pick_text());
          repeat ($urandom_range(0, 2)) put(pick_ws());
        end
      end
      if ($urandom_range(19) == 0) put(NUL_CH);
    end
    put_eol();
  endfunction

  // overruns the whitespace store, then flushes all of it
  function automatic void push_long_line();
    put(SPACE_CH);
    put("x");
    repeat ($urandom_range(33, 36)) put(pick_ws());
    put("y");
    repeat ($urandom_range(1, 3)) put(pick_ws());
    put_eol();
  endfunction

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || expected_tokens.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_delimiter(logic [7:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_field_delimiter <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    delim = d;
    delim_writes++;
  endtask

  initial begin
    int         target;
    logic [7:0] d;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lines, reset delimiter, no idling
    put_eol();
    put(SPACE_CH); put(TAB_CH); put(CR_CH); put_eol();
    put("a"); put(SPACE_CH); put(COMMA_CH); put_eol();
    put(SPACE_CH); put(QUOTE_CH); put("a"); put(COMMA_CH);
    put(QUOTE_CH); put(QUOTE_CH); put(QUOTE_CH); put("z"); put_eol();
    put("b"); put(NUL_CH); put("c"); put_eol();
    put(NUL_CH); put("d"); put_eol();
    put(8'h80); put(COMMA_CH); put(QUOTE_CH); put(8'hFF); put_eol();

    for (int p = 1; p <= 6; p++) begin
      wait_drained();
      case (p)
        1: d = COMMA_CH;
        2: d = TAB_CH;
        3: d = NUL_CH;
        4: d = 8'hFF;
        5: d = 8'd124;
        default: d = SPACE_CH;
      endcase
      write_delimiter(d);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      if (p == 1) push_long_line();
      target = pending_bytes.size() + 8;
      while (pending_bytes.size() < target) push_line();
    end

    wait_drained();
    if (expected_tokens.size() != 0) errors++;
    $display("covered %0d input bytes, %0d results, %0d delimiter writes, %0d overflow ends",
             bytes_in, tokens_checked, delim_writes, overflow_ends);
    if (errors == 0) begin
      $display("csv_line_field_splitter_top: match");
    end else begin
      $display("csv_line_field_splitter_top: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/csvs_pkg.sv
rtl/core/csvs_ram.sv
rtl/core/csv_line_field_splitter_top.sv
rtl/core/csvs_checker.sv
bench/testbench.sv
